FILE: src/fbf_pkg.sv
// ----------------------------------------------------------------------------
// fbf_pkg
// Shared types and codes for the fair blocking fifo: opcodes, result status
// codes, the command struct passed from front to back and the back's occupancy struct.
// ----------------------------------------------------------------------------
package fbf_pkg;

   // fixed field widths
   localparam int ID_BITS     = 3;
   localparam int STATUS_BITS = 3;
   localparam int TOTAL_BITS  = 32;

   // opcodes
   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   // result status codes
   localparam logic [STATUS_BITS-1:0] ST_DELIVERED   = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_STORED      = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_PARKED      = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_DATA_FULL   = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_WAITER_FULL = 3'd4;

   // classified command from front to back
   typedef struct packed {
      logic               is_deq;
      logic [ID_BITS-1:0] req_id;
   } cmd_ctrl_type;

   // occupancy flags from the back
   typedef struct packed {
      logic words_any;
      logic waiters_any;
   } occ_type;

endpackage

FILE: src/fair_blocking_fifo.sv
// ----------------------------------------------------------------------------
// fair_blocking_fifo
// FIFO of data words paired with a FIFO of waiting requesters, served in
// strict arrival order.
// ----------------------------------------------------------------------------
// Usage:
//   req_* channel: one transaction per enqueue (req_opcode 0, req_data_word)
//   or dequeue request (req_opcode 1, req_requester_id). rsp_* channel: one
//   result transaction per request, in order: status, delivered word,
//   served requester, words held and the running delivered count.
//   An enqueue goes straight to the oldest parked requester if any, else it
//   is stored; a dequeue is served at once only when words are held and
//   nobody waits, else the requester is parked. Full stores are reported as
//   data store full / waiter store full and change nothing.
//   The accepting edge writes the front command queue; the back response
//   register is written when the back takes the command, which a held
//   response register can delay.
//   Throughput: one transaction per cycle while rsp_stall is low; all store
//   updates are pointer and count moves made in the back stage.
//   Reset clears all pointers, counts, the delivered counter and both queues.
//   While rsp_stall is high the response register holds; the front queue
//   absorbs up to two more requests before req_stall rises.
// ----------------------------------------------------------------------------
module fair_blocking_fifo import fbf_pkg::*; #(
   parameter int WORD_DEPTH   = 16,
   parameter int WAITER_DEPTH = 8,
   parameter int WORD_BITS    = 32,
   localparam int WC_BITS     = $clog2(WORD_DEPTH + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_opcode,
   input  logic [WORD_BITS-1:0]   req_data_word,
   input  logic [ID_BITS-1:0]     req_requester_id,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [STATUS_BITS-1:0] rsp_status,
   output logic [WORD_BITS-1:0]   rsp_delivered_word,
   output logic [ID_BITS-1:0]     rsp_served_requester,
   output logic [WC_BITS-1:0]     rsp_words_held,
   output logic [TOTAL_BITS-1:0]  rsp_delivered_total
);

   logic                 cmd_valid;
   logic                 cmd_ready;
   cmd_ctrl_type         cmd_ctrl;
   logic [WORD_BITS-1:0] cmd_word;
   occ_type              occ;

   // accept and classify
   fbf_front #(
      .WORD_BITS (WORD_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_data_word    (req_data_word),
      .req_requester_id (req_requester_id),
      .cmd_valid        (cmd_valid),
      .cmd_ready        (cmd_ready),
      .cmd_ctrl         (cmd_ctrl),
      .cmd_word         (cmd_word)
   );

   // execute against the stores
   fbf_back #(
      .WORD_DEPTH   (WORD_DEPTH),
      .WAITER_DEPTH (WAITER_DEPTH),
      .WORD_BITS    (WORD_BITS)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .cmd_valid            (cmd_valid),
      .cmd_ready            (cmd_ready),
      .cmd_ctrl             (cmd_ctrl),
      .cmd_word             (cmd_word),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_delivered_word   (rsp_delivered_word),
      .rsp_served_requester (rsp_served_requester),
      .rsp_words_held       (rsp_words_held),
      .rsp_delivered_total  (rsp_delivered_total),
      .occ                  (occ)
   );

   // words and waiters are never held together
   a_no_words_and_waiters: assert property (@(posedge clock) disable iff (reset)
      !(occ.words_any && occ.waiters_any))
      else $error("words and waiters held at the same time");

   // a parked or refused requester implies an empty word store
   a_parked_no_words: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_PARKED || rsp_status == ST_WAITER_FULL)
      |-> rsp_words_held == '0)
      else $error("requester parked while words are held");

   // data full only at full occupancy
   a_data_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_DATA_FULL
      |-> rsp_words_held == WC_BITS'(WORD_DEPTH))
      else $error("data store full reported below capacity");

   // only a delivery carries a word
   a_word_only_on_delivery: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_DELIVERED |-> rsp_delivered_word == '0)
      else $error("word reported without a delivery");

endmodule

FILE: src/fbf_front.sv
// ----------------------------------------------------------------------------
// fbf_front
// Accepts request transactions, classifies them into commands and holds them
// in a two-entry queue that decouples the request side from the back end.
// ----------------------------------------------------------------------------
module fbf_front import fbf_pkg::*; #(
   parameter int WORD_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_opcode,
   input  logic [WORD_BITS-1:0] req_data_word,
   input  logic [ID_BITS-1:0]   req_requester_id,
   output logic                 cmd_valid,
   input  logic                 cmd_ready,
   output cmd_ctrl_type         cmd_ctrl,
   output logic [WORD_BITS-1:0] cmd_word
);

   cmd_ctrl_type         q_ctrl_ff [2];
   logic [WORD_BITS-1:0] q_word_ff [2];
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]           count_ff, count_in;
   logic                 push, pop;
   cmd_ctrl_type         class_ctrl;

   // classify the incoming transaction
   always_comb begin
      class_ctrl.is_deq = (req_opcode == OP_DEQUEUE);
      class_ctrl.req_id = req_requester_id;
   end

   // queue handshake
   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != 2'd0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd_ctrl  = q_ctrl_ff[rd_ptr_ff];
   assign cmd_word  = q_word_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue payload
   always_ff @(posedge clock) begin
      if (push) begin
         q_ctrl_ff[wr_ptr_ff] <= class_ctrl;
         q_word_ff[wr_ptr_ff] <= req_data_word;
      end
   end

endmodule

FILE: src/fbf_back.sv
// ----------------------------------------------------------------------------
// fbf_back
// Executes commands against the word store and the waiter store and drives
// the registered response transaction.
// ----------------------------------------------------------------------------
module fbf_back import fbf_pkg::*; #(
   parameter int WORD_DEPTH   = 16,
   parameter int WAITER_DEPTH = 8,
   parameter int WORD_BITS    = 32,
   localparam int WP_BITS     = $clog2(WORD_DEPTH),
   localparam int WC_BITS     = $clog2(WORD_DEPTH + 1),
   localparam int AP_BITS     = $clog2(WAITER_DEPTH),
   localparam int AC_BITS     = $clog2(WAITER_DEPTH + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   output logic                   cmd_ready,
   input  cmd_ctrl_type           cmd_ctrl,
   input  logic [WORD_BITS-1:0]   cmd_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [STATUS_BITS-1:0] rsp_status,
   output logic [WORD_BITS-1:0]   rsp_delivered_word,
   output logic [ID_BITS-1:0]     rsp_served_requester,
   output logic [WC_BITS-1:0]     rsp_words_held,
   output logic [TOTAL_BITS-1:0]  rsp_delivered_total,
   output occ_type                occ
);

   localparam logic [1:0] SEL_ZERO = 2'd0;
   localparam logic [1:0] SEL_CMD  = 2'd1;
   localparam logic [1:0] SEL_MEM  = 2'd2;

   logic [WORD_BITS-1:0] word_mem   [WORD_DEPTH];
   logic [ID_BITS-1:0]   waiter_mem [WAITER_DEPTH];

   logic [WP_BITS-1:0]     word_head_ff, word_head_in;
   logic [WP_BITS-1:0]     word_tail_ff, word_tail_in;
   logic [WC_BITS-1:0]     word_count_ff, word_count_in;
   logic [AP_BITS-1:0]     waiter_head_ff, waiter_head_in;
   logic [AP_BITS-1:0]     waiter_tail_ff, waiter_tail_in;
   logic [AC_BITS-1:0]     waiter_count_ff, waiter_count_in;
   logic [TOTAL_BITS-1:0]  total_ff, total_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0] status_ff, status_in;
   logic [WORD_BITS-1:0]   word_out_ff;
   logic [ID_BITS-1:0]     who_out_ff;
   logic [WC_BITS-1:0]     held_ff;

   logic                   take;
   logic                   word_wr_en, waiter_wr_en;
   logic [1:0]             word_sel, who_sel;
   logic                   words_any, waiters_any;
   logic                   words_full, waiters_full;

   // output register frees up when empty or being taken
   assign cmd_ready = !rsp_valid_ff || !rsp_stall;
   assign take      = cmd_valid && cmd_ready;

   assign words_any    = (word_count_ff != '0);
   assign waiters_any  = (waiter_count_ff != '0);
   assign words_full   = (word_count_ff == WC_BITS'(WORD_DEPTH));
   assign waiters_full = (waiter_count_ff == AC_BITS'(WAITER_DEPTH));

   // execute one command
   always_comb begin
      word_head_in    = word_head_ff;
      word_tail_in    = word_tail_ff;
      word_count_in   = word_count_ff;
      waiter_head_in  = waiter_head_ff;
      waiter_tail_in  = waiter_tail_ff;
      waiter_count_in = waiter_count_ff;
      total_in        = total_ff;
      status_in       = status_ff;
      word_wr_en      = 1'b0;
      waiter_wr_en    = 1'b0;
      word_sel        = SEL_ZERO;
      who_sel         = SEL_ZERO;
      if (take) begin
         if (!cmd_ctrl.is_deq) begin
            if (waiters_any) begin
               // hand the word to the oldest waiter
               waiter_head_in  = (waiter_head_ff == AP_BITS'(WAITER_DEPTH - 1)) ?
                                 '0 : waiter_head_ff + 1'b1;
               waiter_count_in = waiter_count_ff - 1'b1;
               total_in        = total_ff + 1'b1;
               status_in       = ST_DELIVERED;
               word_sel        = SEL_CMD;
               who_sel         = SEL_MEM;
            end else if (words_full) begin
               status_in = ST_DATA_FULL;
            end else begin
               word_wr_en    = 1'b1;
               word_tail_in  = (word_tail_ff == WP_BITS'(WORD_DEPTH - 1)) ?
                               '0 : word_tail_ff + 1'b1;
               word_count_in = word_count_ff + 1'b1;
               status_in     = ST_STORED;
            end
         end else begin
            who_sel = SEL_CMD;
            if (words_any && !waiters_any) begin
               // serve the head word right away
               word_head_in  = (word_head_ff == WP_BITS'(WORD_DEPTH - 1)) ?
                               '0 : word_head_ff + 1'b1;
               word_count_in = word_count_ff - 1'b1;
               total_in      = total_ff + 1'b1;
               status_in     = ST_DELIVERED;
               word_sel      = SEL_MEM;
            end else if (waiters_full) begin
               status_in = ST_WAITER_FULL;
            end else begin
               waiter_wr_en    = 1'b1;
               waiter_tail_in  = (waiter_tail_ff == AP_BITS'(WAITER_DEPTH - 1)) ?
                                 '0 : waiter_tail_ff + 1'b1;
               waiter_count_in = waiter_count_ff + 1'b1;
               status_in       = ST_PARKED;
            end
         end
      end
   end

   // response valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         word_head_ff    <= '0;
         word_tail_ff    <= '0;
         word_count_ff   <= '0;
         waiter_head_ff  <= '0;
         waiter_tail_ff  <= '0;
         waiter_count_ff <= '0;
         total_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         word_head_ff    <= word_head_in;
         word_tail_ff    <= word_tail_in;
         word_count_ff   <= word_count_in;
         waiter_head_ff  <= waiter_head_in;
         waiter_tail_ff  <= waiter_tail_in;
         waiter_count_ff <= waiter_count_in;
         total_ff        <= total_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // stores and registered response payload
   always_ff @(posedge clock) begin
      if (word_wr_en) begin
         word_mem[word_tail_ff] <= cmd_word;
      end
      if (waiter_wr_en) begin
         waiter_mem[waiter_tail_ff] <= cmd_ctrl.req_id;
      end
      if (take) begin
         status_ff <= status_in;
         held_ff   <= word_count_in;
         case (word_sel)
            SEL_MEM: word_out_ff <= word_mem[word_head_ff];
            SEL_CMD: word_out_ff <= cmd_word;
            default: word_out_ff <= '0;
         endcase
         case (who_sel)
            SEL_MEM: who_out_ff <= waiter_mem[waiter_head_ff];
            SEL_CMD: who_out_ff <= cmd_ctrl.req_id;
            default: who_out_ff <= '0;
         endcase
      end
   end

   // the counter is sampled with the response; it only moves on a take
   logic [TOTAL_BITS-1:0] total_out_ff;
   always_ff @(posedge clock) begin
      if (take) begin
         total_out_ff <= total_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = status_ff;
   assign rsp_delivered_word   = word_out_ff;
   assign rsp_served_requester = who_out_ff;
   assign rsp_words_held       = held_ff;
   assign rsp_delivered_total  = total_out_ff;
   assign occ.words_any        = words_any;
   assign occ.waiters_any      = waiters_any;

endmodule
